### rtl/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// shared types and constants of the round-robin ready queue
// ----------------------------------------------------------------------------
package rrq_pkg;

  // width of a task number on the ports and in the queue entries
  localparam int unsigned TASK_W = 4;
  localparam int unsigned ACT_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_MARK_READY     = 2'd0,
    ACT_MARK_NOT_READY = 2'd1,
    ACT_SWITCH         = 2'd2,
    ACT_CLEAR          = 2'd3
  } action_t;

endpackage

### rtl/rrq_ram.sv
// ----------------------------------------------------------------------------
// rrq_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rrq_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/round_robin_ready_queue_top.sv
// ----------------------------------------------------------------------------
// round_robin_ready_queue_top
// fifo ready queue of task numbers with per-task ready flags and a running
// task; actions are mark ready, mark not ready, switch and clear current
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   -------   ---------   ------------------   ----------------------------------
//   in        sink        in_valid/in_ready    action, task_present, task_id
//   out       source      out_valid/out_ready  accepted, run_valid, run_task,
//                                              space_change, sleeping,
//                                              append_dropped
//
// one request beat gives exactly one result beat
// mark ready, clear current, refused marks, and switch or mark not ready on an
//   empty queue: idle, then done
// switch on a non-empty queue: idle, pop, done (registered read of the head)
// mark not ready on a non-empty queue: idle, a scan over the queue ram with
//   one entry read per cycle, then done; entries behind the match are
//   shifted down by one on the write port in the same pass
// a new request is taken once the previous one has its result in the output
//   register, even if that result is still stalled there
// reset clears pointers, count, ready flags and the running task; the queue
//   ram holds no reset value and is never read past queue_count
//
module round_robin_ready_queue_top
  import rrq_pkg::*;
#(
  parameter int unsigned NUM_TASKS   = 16,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic              task_present,
  input  logic [TASK_W-1:0] task_id,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              accepted,
  output logic              run_valid,
  output logic [TASK_W-1:0] run_task,
  output logic              space_change,
  output logic              sleeping,
  output logic              append_dropped
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TIDX_W = $clog2(NUM_TASKS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_DONE
  } state_t;

  state_t state;

  // queue bookkeeping: circular buffer in ram, head and tail addresses
  logic [PTR_W-1:0]     hd;
  logic [PTR_W-1:0]     tl;
  logic [CNT_W-1:0]     q_count;
  logic                 q_full;

  // per-task ready flags, reset to not ready
  logic [NUM_TASKS-1:0] flags;

  // running task
  logic                 running_valid;
  logic [TASK_W-1:0]    running_task;

  // request held while it is worked on
  logic [TASK_W-1:0]    task_reg;

  // result fields collected during the work
  logic                 res_acc;
  logic                 res_space;
  logic                 res_sleep;
  logic                 res_drop;

  // removal scan: reads stream from the head, matched entry is overwritten
  // by shifting every later entry down by one address
  logic [PTR_W-1:0]     scan_addr;
  logic [CNT_W-1:0]     scan_left;
  logic                 pend;
  logic [PTR_W-1:0]     pend_addr;
  logic [PTR_W-1:0]     prev_addr;
  logic                 found;

  // ram ports
  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [TASK_W-1:0]    ram_wdata;
  logic [PTR_W-1:0]     ram_raddr;
  logic [TASK_W-1:0]    ram_rdata;

  // decoded request
  logic                 in_fire;
  action_t              in_act;
  logic                 task_in_range;
  logic                 mark_ok;
  logic [TIDX_W-1:0]    task_idx;
  logic [TIDX_W-1:0]    run_idx;
  logic                 cur_requeue;
  logic                 switch_new;

  // append request from the current cycle, shared by mark ready, switch and clear current
  logic                 app_en;
  logic [TASK_W-1:0]    app_task;
  logic                 app_do;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
  endfunction

  assign in_ready      = (state == ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign in_act        = action_t'(action);
  assign task_in_range = (32'(task_id) < 32'(NUM_TASKS));
  assign mark_ok       = task_present && task_in_range;
  assign task_idx      = TIDX_W'(task_id);
  assign run_idx       = TIDX_W'(running_task);
  assign q_full        = (q_count == CNT_W'(QUEUE_DEPTH));

  // the running task goes back into the queue when it is stopped while ready
  assign cur_requeue   = running_valid && flags[run_idx];
  // popped head in ram_rdata during the pop cycle
  assign switch_new    = !running_valid || (ram_rdata != running_task);

  always_comb begin
    app_en   = 1'b0;
    app_task = running_task;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_act)
            ACT_MARK_READY: begin
              app_en   = mark_ok;
              app_task = task_id;
            end
            ACT_SWITCH: begin
              app_en = (q_count == '0) && cur_requeue;
            end
            ACT_CLEAR: begin
              app_en = cur_requeue;
            end
            default: begin
              // mark not ready never requeues: the flag is cleared first
              app_en = 1'b0;
            end
          endcase
        end
      end
      ST_POP: begin
        app_en = switch_new && cur_requeue;
      end
      default: begin
        app_en = 1'b0;
      end
    endcase
  end

  assign app_do = app_en && !q_full;

  // ram port steering: the scan owns both ports, otherwise appends write at
  // the tail and reads go to the head
  always_comb begin
    if (state == ST_SCAN) begin
      ram_we    = pend && found;
      ram_waddr = prev_addr;
      ram_wdata = ram_rdata;
      ram_raddr = scan_addr;
    end else begin
      ram_we    = app_do;
      ram_waddr = tl;
      ram_wdata = app_task;
      ram_raddr = hd;
    end
  end

  rrq_ram #(
    .WIDTH (TASK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      hd            <= '0;
      tl            <= '0;
      q_count       <= '0;
      flags         <= '0;
      running_valid <= 1'b0;
      running_task  <= '0;
      pend          <= 1'b0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            task_reg  <= task_id;
            res_acc   <= 1'b1;
            res_space <= 1'b0;
            res_sleep <= 1'b0;
            res_drop  <= app_en && q_full;
            state     <= ST_DONE;
            unique case (in_act)
              ACT_MARK_READY: begin
                if (mark_ok) begin
                  flags[task_idx] <= 1'b1;
                end else begin
                  res_acc <= 1'b0;
                end
              end
              ACT_MARK_NOT_READY: begin
                if (mark_ok) begin
                  flags[task_idx] <= 1'b0;
                  if (running_valid && running_task == task_id) begin
                    running_valid <= 1'b0;
                    running_task  <= '0;
                  end
                  if (q_count != '0) begin
                    // start the removal pass at the head
                    scan_addr <= hd;
                    scan_left <= q_count;
                    pend      <= 1'b0;
                    found     <= 1'b0;
                    state     <= ST_SCAN;
                  end
                end else begin
                  res_acc <= 1'b0;
                end
              end
              ACT_SWITCH: begin
                if (q_count != '0) begin
                  // head read is under way, pop it now
                  hd      <= ptr_inc(hd);
                  q_count <= q_count - CNT_W'(1);
                  state   <= ST_POP;
                end else begin
                  running_valid <= 1'b0;
                  running_task  <= '0;
                  res_sleep     <= 1'b1;
                end
              end
              ACT_CLEAR: begin
                running_valid <= 1'b0;
                running_task  <= '0;
              end
              default: begin
                res_acc <= 1'b1;
              end
            endcase
          end
        end

        ST_POP: begin
          // the old task is requeued by the append logic when it differs and is still ready
          res_drop      <= app_en && q_full;
          res_space     <= switch_new;
          running_valid <= 1'b1;
          running_task  <= ram_rdata;
          state         <= ST_DONE;
        end

        ST_SCAN: begin
          // issue side
          if (scan_left != '0) begin
            scan_addr <= ptr_inc(scan_addr);
            scan_left <= scan_left - CNT_W'(1);
            pend      <= 1'b1;
            pend_addr <= scan_addr;
          end else begin
            pend <= 1'b0;
          end
          // receive side: first copy found, later entries move down
          if (pend) begin
            if (!found && ram_rdata == task_reg) begin
              found <= 1'b1;
            end
            prev_addr <= pend_addr;
          end
          // pass complete once the last read has been consumed
          if (scan_left == '0 && !pend) begin
            if (found) begin
              q_count <= q_count - CNT_W'(1);
              tl      <= ptr_dec(tl);
            end
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            accepted       <= res_acc;
            run_valid      <= running_valid;
            run_task       <= running_task;
            space_change   <= res_space;
            sleeping       <= res_sleep;
            append_dropped <= res_drop;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase

      // tail side of an append, from mark ready or a stopped running task
      if (app_do) begin
        tl      <= ptr_inc(tl);
        q_count <= q_count + CNT_W'(1);
      end
    end
  end

  // queue occupancy never passes the ram depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // during the shift the write trails the read, never the same entry
  a_scan_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && pend && found && scan_left != '0) |-> (prev_addr != scan_addr))
    else $error("scan write hits the entry being read");

  // a switch result is either a change of task or sleep, never both
  a_switch_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(space_change && sleeping))
    else $error("space change and sleep together");

  // an idle cpu reports task zero
  a_idle_task_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !run_valid) |-> (run_task == '0))
    else $error("task number reported with nothing running");

  // a pop always lands in a slot, the requeue after it cannot overflow
  a_pop_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> !q_full)
    else $error("queue full right after a pop");

endmodule

### tb/rrq_sched_monitor.sv
// ----------------------------------------------------------------------------
// rrq_sched_monitor
// watches the request and result channels of the ready queue, predicts every
// result beat from its own copy of the scheduler state and compares in order
// ----------------------------------------------------------------------------
module rrq_sched_monitor
  import rrq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic              task_present,
  input  logic [TASK_W-1:0] task_id,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              accepted,
  input  logic              run_valid,
  input  logic [TASK_W-1:0] run_task,
  input  logic              space_change,
  input  logic              sleeping,
  input  logic              append_dropped,
  output int                errors,
  output int                results_owed,
  output int                drops_seen,
  output int                sleeps_seen,
  output int                changes_seen
);

  localparam int NTASK  = 16;
  localparam int QDEPTH = 16;

  typedef struct packed {
    logic              accepted;
    logic              run_valid;
    logic [TASK_W-1:0] run_task;
    logic              space_change;
    logic              sleeping;
    logic              append_dropped;
  } sched_result_t;

  // predicted scheduler state
  logic [TASK_W-1:0] ready_fifo [QDEPTH];
  int                fifo_count;
  bit                ready_flag [NTASK];
  bit                cur_valid;
  logic [TASK_W-1:0] cur_task;
  bit                dropped;

  sched_result_t results_due[$];

  function automatic void append_task(input logic [TASK_W-1:0] t);
    if (fifo_count >= QDEPTH) begin
      dropped = 1'b1;
    end else begin
      ready_fifo[fifo_count] = t;
      fifo_count++;
    end
  endfunction

  function automatic void unqueue_at(input int pos);
    int i;
    for (i = pos; i + 1 < fifo_count; i++) ready_fifo[i] = ready_fifo[i+1];
    fifo_count--;
  endfunction

  // running task goes back to the queue if still ready
  function automatic void stop_running();
    if (cur_valid) begin
      if (ready_flag[cur_task]) append_task(cur_task);
      cur_valid = 1'b0;
      cur_task  = '0;
    end
  endfunction

  function automatic sched_result_t next_schedule(input action_t a, input logic named,
                                                  input logic [TASK_W-1:0] id);
    sched_result_t     r;
    logic [TASK_W-1:0] head;
    int                i;
    int                pos;
    r          = '0;
    r.accepted = 1'b1;
    dropped    = 1'b0;
    case (a)
      ACT_MARK_READY, ACT_MARK_NOT_READY: begin
        if (!named || int'(id) >= NTASK) begin
          r.accepted = 1'b0;
        end else if (a == ACT_MARK_READY) begin
          ready_flag[id] = 1'b1;
          append_task(id);
        end else begin
          ready_flag[id] = 1'b0;
          pos = -1;
          for (i = 0; i < fifo_count; i++)
            if (pos < 0 && ready_fifo[i] == id) pos = i;
          if (pos >= 0) unqueue_at(pos);
          if (cur_valid && cur_task == id) stop_running();
        end
      end
      ACT_SWITCH: begin
        if (fifo_count > 0) begin
          head = ready_fifo[0];
          unqueue_at(0);
          if (!cur_valid || head != cur_task) begin
            stop_running();
            r.space_change = 1'b1;
          end
          cur_valid = 1'b1;
          cur_task  = head;
        end else begin
          stop_running();
          r.sleeping = 1'b1;
        end
      end
      default: stop_running();
    endcase
    r.run_valid      = cur_valid;
    r.run_task       = cur_valid ? cur_task : '0;
    r.append_dropped = dropped;
    return r;
  endfunction

  function automatic string show(input sched_result_t r);
    return $sformatf("acc=%0b run=%0b task=%0d chg=%0b sleep=%0b drop=%0b", r.accepted,
                     r.run_valid, r.run_task, r.space_change, r.sleeping, r.append_dropped);
  endfunction

  always @(posedge clk) begin : watch
    sched_result_t want;
    sched_result_t got;
    int            i;
    if (rst) begin
      fifo_count   = 0;
      cur_valid    = 1'b0;
      cur_task     = '0;
      for (i = 0; i < NTASK; i++) ready_flag[i] = 1'b0;
      results_due.delete();
      errors       = 0;
      drops_seen   = 0;
      sleeps_seen  = 0;
      changes_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {accepted, run_valid, run_task, space_change, sleeping, append_dropped};
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result beat with nothing pending: %s", $time, show(got));
        end else begin
          want = results_due.pop_front();
          if (want !== got) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch\n  expected %s\n  actual   %s", $time, show(want),
                       show(got));
          end
        end
        drops_seen   += int'(got.append_dropped);
        sleeps_seen  += int'(got.sleeping);
        changes_seen += int'(got.space_change);
      end
      if (in_valid && in_ready)
        results_due.push_back(next_schedule(action_t'(action), task_present, task_id));
    end
    results_owed = results_due.size();
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives the round-robin ready queue with directed and random request beats,
// random idling on both channels and long output stalls; a monitor predicts
// and checks every result beat, this module reports the verdict
// ----------------------------------------------------------------------------
module tb_top
  import rrq_pkg::*;
();

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [ACT_W-1:0]  action;
  logic              task_present;
  logic [TASK_W-1:0] task_id;
  logic              out_valid;
  logic              out_ready;
  logic              accepted;
  logic              run_valid;
  logic [TASK_W-1:0] run_task;
  logic              space_change;
  logic              sleeping;
  logic              append_dropped;

  int errors;
  int results_owed;
  int drops_seen;
  int sleeps_seen;
  int changes_seen;

  // knobs shared between the sender and the receiver
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_req  = 1'b0;
  int sent_by_act [4];

  // 10 time unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  round_robin_ready_queue_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .task_present   (task_present),
    .task_id        (task_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .run_valid      (run_valid),
    .run_task       (run_task),
    .space_change   (space_change),
    .sleeping       (sleeping),
    .append_dropped (append_dropped)
  );

  rrq_sched_monitor mon (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .task_present   (task_present),
    .task_id        (task_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .run_valid      (run_valid),
    .run_task       (run_task),
    .space_change   (space_change),
    .sleeping       (sleeping),
    .append_dropped (append_dropped),
    .errors         (errors),
    .results_owed   (results_owed),
    .drops_seen     (drops_seen),
    .sleeps_seen    (sleeps_seen),
    .changes_seen   (changes_seen)
  );

  // one request beat; called and returns at a falling edge
  task automatic send_beat(input action_t a, input logic named, input logic [TASK_W-1:0] id);
    int gap;
    // random idle burst, with junk on the payload while valid is low
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap          = $urandom_range(1, 11);
      in_valid     <= 1'b0;
      action       <= ACT_W'($urandom_range(0, 3));
      task_present <= 1'($urandom_range(0, 1));
      task_id      <= TASK_W'($urandom_range(0, 15));
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    action       <= a;
    task_present <= named;
    task_id      <= id;
    sent_by_act[a]++;
    // hold the beat until the block takes it
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random beat; weights are percent for mark ready, mark not ready and switch,
  // the rest goes to clear current
  task automatic send_random(input int w_rdy, input int w_nrdy, input int w_sw);
    int                roll;
    action_t           a;
    logic [TASK_W-1:0] id;
    roll = $urandom_range(0, 99);
    if (roll < w_rdy) a = ACT_MARK_READY;
    else if (roll < w_rdy + w_nrdy) a = ACT_MARK_NOT_READY;
    else if (roll < w_rdy + w_nrdy + w_sw) a = ACT_SWITCH;
    else a = ACT_CLEAR;
    // half the ids from a small pool so removals and duplicates hit queued tasks
    if ($urandom_range(0, 1)) id = TASK_W'($urandom_range(0, 3));
    else id = TASK_W'($urandom_range(0, 15));
    // the null task now and then
    send_beat(a, $urandom_range(0, 19) != 0, id);
  endtask

  // receiver: random stalls, and one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        // long hold so the block backs up and drops in_ready
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // stimulus
  initial begin
    int i;
    int phase;
    int k;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = ACT_MARK_READY;
    task_present = 1'b0;
    task_id      = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty queue, null task, duplicates, same-task switch,
    // stopping the running task, then fill the queue past full
    send_beat(ACT_SWITCH, 1'b0, 4'd0);          // empty queue, sleep
    send_beat(ACT_CLEAR, 1'b1, 4'd15);          // nothing running
    send_beat(ACT_MARK_READY, 1'b0, 4'd15);     // null task refused
    send_beat(ACT_MARK_NOT_READY, 1'b0, 4'd0);  // null task refused
    send_beat(ACT_MARK_READY, 1'b1, 4'd0);
    send_beat(ACT_MARK_READY, 1'b1, 4'd0);      // duplicate entry
    send_beat(ACT_SWITCH, 1'b1, 4'd9);          // new task, space change
    send_beat(ACT_SWITCH, 1'b0, 4'd3);          // head equals running task
    send_beat(ACT_MARK_NOT_READY, 1'b1, 4'd5);  // task not queued
    send_beat(ACT_MARK_NOT_READY, 1'b1, 4'd0);  // stops the running task
    // seventeen appends into an empty queue: the last one is dropped
    for (i = 0; i <= 16; i++) send_beat(ACT_MARK_READY, 1'b1, i[TASK_W-1:0]);

    // random: phases alternate between filling, mixing and draining
    for (phase = 0; phase < 9; phase++) begin
      // no idling at all in the last stretch
      if (phase >= 7) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      // long receiver hold while the sender keeps offering beats
      if (phase == 2) hold_req = 1'b1;
      for (k = 0; k < 100; k++) begin
        case (phase % 3)
          0:       send_random(60, 15, 20);
          1:       send_random(30, 25, 35);
          default: send_random(15, 15, 60);
        endcase
      end
      // sender pause until every result is back
      if (phase == 4) begin
        in_valid <= 1'b0;
        wait (results_owed == 0);
        @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    // drain until every result is back, then let the bench idle before the report
    wait (results_owed == 0);
    repeat (40) @(negedge clk);

    $display("covered %0d mark ready, %0d mark not ready, %0d switch, %0d clear current beats",
             sent_by_act[ACT_MARK_READY], sent_by_act[ACT_MARK_NOT_READY],
             sent_by_act[ACT_SWITCH], sent_by_act[ACT_CLEAR]);
    $display("results showed %0d full-queue drops, %0d empty-queue sleeps, %0d task changes",
             drops_seen, sleeps_seen, changes_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
